// ===== rtl/nzt_pkg.sv =====
// nzt_pkg: shared types, constants and helpers of the zda time parser
package nzt_pkg;

   // field widths
   localparam int BYTE_W   = 8;
   localparam int YEAR_W   = 14;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int HOUR_W   = 5;
   localparam int MINSEC_W = 7;
   localparam int TIME_W   = 24;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 14;

   // ascii codes the parser reacts to
   localparam logic [BYTE_W-1:0] CH_DOLLAR  = 8'h24;
   localparam logic [BYTE_W-1:0] CH_COMMA   = 8'h2C;
   localparam logic [BYTE_W-1:0] CH_STAR    = 8'h2A;
   localparam logic [BYTE_W-1:0] CH_CR      = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_LF      = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
   localparam logic [BYTE_W-1:0] CH_NINE    = 8'h39;
   localparam logic [BYTE_W-1:0] CH_UPPER_A = 8'h41;
   localparam logic [BYTE_W-1:0] CH_UPPER_F = 8'h46;
   localparam logic [BYTE_W-1:0] CH_LOWER_A = 8'h61;
   localparam logic [BYTE_W-1:0] CH_LOWER_F = 8'h66;

   // register reset values and the largest hour
   localparam logic [HOUR_W-1:0] OFFSET_RESET   = 5'd6;
   localparam logic [YEAR_W-1:0] MIN_YEAR_RESET = 14'd2024;
   localparam logic [HOUR_W-1:0] HOUR_MAX       = 5'd23;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NO_STAR  = 2'd1,
      ST_BAD_SUM  = 2'd2,
      ST_OLD_YEAR = 2'd3
   } nzt_status_type;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_OFFSET_HOURS = 1'b0,
      REG_MIN_YEAR     = 1'b1
   } nzt_reg_type;

   typedef struct packed {
      logic [HOUR_W-1:0] offset_hours;
      logic [YEAR_W-1:0] min_year;
   } nzt_cfg_type;

   // what a closed sentence hands to the local time stage
   typedef struct packed {
      logic              saw_star;
      logic              sum_ok;
      logic [TIME_W-1:0] time_bcd;
      logic [YEAR_W-1:0] day;
      logic [YEAR_W-1:0] month;
      logic [YEAR_W-1:0] year;
   } nzt_close_type;

   typedef struct packed {
      nzt_status_type      status;
      logic [YEAR_W-1:0]   year_out;
      logic [MONTH_W-1:0]  month_out;
      logic [DAY_W-1:0]    day_out;
      logic [HOUR_W-1:0]   hour_out;
      logic [MINSEC_W-1:0] minute_out;
      logic [MINSEC_W-1:0] second_out;
   } nzt_result_type;

   // four bcd digits to binary, at most 9999
   function automatic logic [YEAR_W-1:0] bcd4_to_bin(input logic [15:0] bcd);
      logic [YEAR_W-1:0] val;
      val = YEAR_W'(bcd[15:12]) * 14'd1000 + YEAR_W'(bcd[11:8]) * 14'd100
          + YEAR_W'(bcd[7:4]) * 14'd10 + YEAR_W'(bcd[3:0]);
      return val;
   endfunction

   // two bcd digits to binary, at most 99
   function automatic logic [MINSEC_W-1:0] bcd2_to_bin(input logic [7:0] bcd);
      logic [MINSEC_W-1:0] val;
      val = MINSEC_W'(bcd[7:4]) * 7'd10 + MINSEC_W'(bcd[3:0]);
      return val;
   endfunction

   // length of a month, leap february when the year divides by four
   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
      logic [DAY_W-1:0] days;
      case (month)
         4'd2:                      days = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   days = 5'd30;
         default:                   days = 5'd31;
      endcase
      return days;
   endfunction

endpackage

// ===== rtl/nzt_if.sv =====
// nzt_if: handshake channels of the zda time parser

// received byte channel
interface nzt_req_if;
   logic                       valid;
   logic                       ready;
   logic [nzt_pkg::BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// result channel
interface nzt_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   status;
   logic [nzt_pkg::YEAR_W-1:0]   year_out;
   logic [nzt_pkg::MONTH_W-1:0]  month_out;
   logic [nzt_pkg::DAY_W-1:0]    day_out;
   logic [nzt_pkg::HOUR_W-1:0]   hour_out;
   logic [nzt_pkg::MINSEC_W-1:0] minute_out;
   logic [nzt_pkg::MINSEC_W-1:0] second_out;

   modport source (output valid, output status, output year_out, output month_out,
                   output day_out, output hour_out, output minute_out,
                   output second_out, input ready);
   modport sink   (input valid, input status, input year_out, input month_out,
                   input day_out, input hour_out, input minute_out,
                   input second_out, output ready);
endinterface

// configuration write channel
interface nzt_csr_if;
   logic                           valid;
   logic                           ready;
   logic [nzt_pkg::CSR_IDX_W-1:0]  reg_index;
   logic [nzt_pkg::CSR_DATA_W-1:0] wdata;

   modport source (output valid, output reg_index, output wdata, input ready);
   modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// ===== rtl/nmea_zda_time_parser_top.sv =====
// path: the closing lf item passes the close register, then the result register
// throughput: one byte item per cycle while the close register is free or taken;
//   both registers are separate stages, so bytes flow while one result waits to be taken
// reset: synchronous, active high; clears the parser to idle, empties both stages and
//   sets offset_hours to 6 and min_year to 2024
module nmea_zda_time_parser_top (
   input logic      clock,
   input logic      reset,
   nzt_req_if.sink  req_ch,
   nzt_rsp_if.source rsp_ch,
   nzt_csr_if.sink  csr_ch
);

   nzt_pkg::nzt_cfg_type    cfg_ff, cfg_in;
   nzt_pkg::nzt_close_type  close_item;
   nzt_pkg::nzt_result_type result;
   logic                    close_valid;
   logic                    close_ready;

   // configuration registers, always writable
   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (nzt_pkg::nzt_reg_type'(csr_ch.reg_index))
            nzt_pkg::REG_OFFSET_HOURS: cfg_in.offset_hours = csr_ch.wdata[4:0];
            nzt_pkg::REG_MIN_YEAR:     cfg_in.min_year     = csr_ch.wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.offset_hours <= nzt_pkg::OFFSET_RESET;
         cfg_ff.min_year     <= nzt_pkg::MIN_YEAR_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // sentence parser
   nzt_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .byte_valid  (req_ch.valid),
      .byte_ready  (req_ch.ready),
      .rx_byte     (req_ch.rx_byte),
      .close_valid (close_valid),
      .close_ready (close_ready),
      .close_item  (close_item)
   );

   // local time and result register
   nzt_local_time u_local_time (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (close_valid),
      .in_ready  (close_ready),
      .in_item   (close_item),
      .cfg       (cfg_ff),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_item  (result)
   );

   // result item onto the channel
   assign rsp_ch.status     = result.status;
   assign rsp_ch.year_out   = result.year_out;
   assign rsp_ch.month_out  = result.month_out;
   assign rsp_ch.day_out    = result.day_out;
   assign rsp_ch.hour_out   = result.hour_out;
   assign rsp_ch.minute_out = result.minute_out;
   assign rsp_ch.second_out = result.second_out;

endmodule

// ===== rtl/nzt_parser.sv =====
// nzt_parser: byte level sentence parser with a one item close register
module nzt_parser (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       byte_valid,
   output logic                       byte_ready,
   input  logic [nzt_pkg::BYTE_W-1:0] rx_byte,
   output logic                       close_valid,
   input  logic                       close_ready,
   output nzt_pkg::nzt_close_type     close_item
);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_BODY,
      PH_SUM
   } phase_type;

   localparam logic [2:0] FIELD_TIME  = 3'd1;
   localparam logic [2:0] FIELD_DAY   = 3'd2;
   localparam logic [2:0] FIELD_MONTH = 3'd3;
   localparam logic [2:0] FIELD_YEAR  = 3'd4;
   localparam logic [2:0] FIELD_LAST  = 3'd7;

   phase_type                      phase_ff, phase_in;
   logic [7:0]                     running_xor_ff, running_xor_in;
   logic [7:0]                     given_sum_ff, given_sum_in;
   logic [2:0]                     field_number_ff, field_number_in;
   logic [nzt_pkg::TIME_W-1:0]     accum_ff, accum_in;
   logic                           in_fraction_ff, in_fraction_in;
   logic [nzt_pkg::TIME_W-1:0]     time_ff, time_in;
   logic [nzt_pkg::YEAR_W-1:0]     day_ff, day_in;
   logic [nzt_pkg::YEAR_W-1:0]     month_ff, month_in;
   logic [nzt_pkg::YEAR_W-1:0]     year_ff, year_in;
   logic                           saw_cr_ff, saw_cr_in;
   logic                           saw_star_ff, saw_star_in;
   logic                           close_valid_ff, close_valid_in;
   nzt_pkg::nzt_close_type         close_ff, close_in;

   logic                           accept;
   logic                           is_digit;
   logic                           is_alpha_hex;
   logic [3:0]                     hex_val;
   logic                           sat;
   logic [nzt_pkg::TIME_W-1:0]     sat_val;

   assign byte_ready  = !close_valid_ff || close_ready;
   assign accept      = byte_valid && byte_ready;
   assign close_valid = close_valid_ff;
   assign close_item  = close_ff;

   // character classes
   assign is_digit = (rx_byte >= nzt_pkg::CH_ZERO) && (rx_byte <= nzt_pkg::CH_NINE);
   assign is_alpha_hex = ((rx_byte >= nzt_pkg::CH_UPPER_A) && (rx_byte <= nzt_pkg::CH_UPPER_F))
                      || ((rx_byte >= nzt_pkg::CH_LOWER_A) && (rx_byte <= nzt_pkg::CH_LOWER_F));
   assign hex_val  = is_digit ? rx_byte[3:0] : (rx_byte[3:0] + 4'd9);

   // bcd accumulator saturation: six digits for the time field, four elsewhere
   always_comb begin
      if (field_number_ff == FIELD_TIME) begin
         sat     = (accum_ff[23:20] != 4'd0);
         sat_val = 24'h999999;
      end else begin
         sat     = (accum_ff[15:12] != 4'd0);
         sat_val = 24'h009999;
      end
   end

   // next state for one accepted byte
   always_comb begin
      phase_in        = phase_ff;
      running_xor_in  = running_xor_ff;
      given_sum_in    = given_sum_ff;
      field_number_in = field_number_ff;
      accum_in        = accum_ff;
      in_fraction_in  = in_fraction_ff;
      time_in         = time_ff;
      day_in          = day_ff;
      month_in        = month_ff;
      year_in         = year_ff;
      saw_cr_in       = saw_cr_ff;
      saw_star_in     = saw_star_ff;
      close_valid_in  = close_valid_ff && !close_ready;
      close_in        = close_ff;

      if (accept) begin
         if (rx_byte == nzt_pkg::CH_DOLLAR) begin
            // open a sentence, dropping any open one
            phase_in        = PH_BODY;
            running_xor_in  = 8'd0;
            given_sum_in    = 8'd0;
            field_number_in = 3'd0;
            accum_in        = '0;
            in_fraction_in  = 1'b0;
            time_in         = '0;
            day_in          = '0;
            month_in        = '0;
            year_in         = '0;
            saw_cr_in       = 1'b0;
            saw_star_in     = 1'b0;
         end else if (phase_ff != PH_IDLE && rx_byte == nzt_pkg::CH_LF && saw_cr_ff) begin
            // cr lf closes the sentence
            phase_in          = PH_IDLE;
            saw_cr_in         = 1'b0;
            close_valid_in    = 1'b1;
            close_in.saw_star = saw_star_ff;
            close_in.sum_ok   = (running_xor_ff == given_sum_ff);
            close_in.time_bcd = time_ff;
            close_in.day      = day_ff;
            close_in.month    = month_ff;
            close_in.year     = year_ff;
         end else begin
            unique case (phase_ff)
               PH_IDLE: begin
               end
               PH_BODY: begin
                  saw_cr_in = (rx_byte == nzt_pkg::CH_CR);
                  if (rx_byte == nzt_pkg::CH_STAR) begin
                     phase_in       = PH_SUM;
                     saw_star_in    = 1'b1;
                     given_sum_in   = 8'd0;
                     in_fraction_in = 1'b0;
                  end else begin
                     running_xor_in = running_xor_ff ^ rx_byte;
                     if (rx_byte == nzt_pkg::CH_COMMA) begin
                        // a comma latches the field that it ends
                        case (field_number_ff)
                           FIELD_TIME:  time_in  = accum_ff;
                           FIELD_DAY:   day_in   = nzt_pkg::bcd4_to_bin(accum_ff[15:0]);
                           FIELD_MONTH: month_in = nzt_pkg::bcd4_to_bin(accum_ff[15:0]);
                           FIELD_YEAR:  year_in  = nzt_pkg::bcd4_to_bin(accum_ff[15:0]);
                           default: begin
                           end
                        endcase
                        accum_in       = '0;
                        in_fraction_in = 1'b0;
                        if (field_number_ff != FIELD_LAST) begin
                           field_number_in = field_number_ff + 3'd1;
                        end
                     end else if (is_digit) begin
                        if (!in_fraction_ff) begin
                           accum_in = sat ? sat_val : {accum_ff[19:0], rx_byte[3:0]};
                        end
                     end else begin
                        in_fraction_in = 1'b1;
                     end
                  end
               end
               PH_SUM: begin
                  saw_cr_in = (rx_byte == nzt_pkg::CH_CR);
                  // hex digits shift in until the first other byte
                  if (!(is_digit || is_alpha_hex)) begin
                     in_fraction_in = 1'b1;
                  end else if (!in_fraction_ff) begin
                     given_sum_in = {given_sum_ff[3:0], hex_val};
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end
   end

   // state and close register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         running_xor_ff  <= 8'd0;
         given_sum_ff    <= 8'd0;
         field_number_ff <= 3'd0;
         accum_ff        <= '0;
         in_fraction_ff  <= 1'b0;
         time_ff         <= '0;
         day_ff          <= '0;
         month_ff        <= '0;
         year_ff         <= '0;
         saw_cr_ff       <= 1'b0;
         saw_star_ff     <= 1'b0;
         close_valid_ff  <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         running_xor_ff  <= running_xor_in;
         given_sum_ff    <= given_sum_in;
         field_number_ff <= field_number_in;
         accum_ff        <= accum_in;
         in_fraction_ff  <= in_fraction_in;
         time_ff         <= time_in;
         day_ff          <= day_in;
         month_ff        <= month_in;
         year_ff         <= year_in;
         saw_cr_ff       <= saw_cr_in;
         saw_star_ff     <= saw_star_in;
         close_valid_ff  <= close_valid_in;
      end
      close_ff <= close_in;
   end

`ifndef SYNTH
   // checksum phase is only entered through an asterisk
   a_sum_has_star: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_SUM |-> saw_star_ff)
      else $error("checksum phase without asterisk");

   // a dollar always restarts the sentence
   a_dollar_opens: assert property (@(posedge clock) disable iff (reset)
      accept && rx_byte == nzt_pkg::CH_DOLLAR |=>
         phase_ff == PH_BODY && running_xor_ff == 8'd0 && field_number_ff == 3'd0)
      else $error("dollar did not open a sentence");

   // accumulator stays well formed bcd
   a_accum_bcd: assert property (@(posedge clock) disable iff (reset)
      accum_ff[23:20] <= 4'd9 && accum_ff[19:16] <= 4'd9 && accum_ff[15:12] <= 4'd9
      && accum_ff[11:8] <= 4'd9 && accum_ff[7:4] <= 4'd9 && accum_ff[3:0] <= 4'd9)
      else $error("accumulator digit above nine");
`endif

endmodule

// ===== rtl/nzt_local_time.sv =====
// nzt_local_time: status, utc to local shift and the result register
module nzt_local_time (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  nzt_pkg::nzt_close_type in_item,
   input  nzt_pkg::nzt_cfg_type   cfg,
   output logic                   out_valid,
   input  logic                   out_ready,
   output nzt_pkg::nzt_result_type out_item
);

   logic                            out_valid_ff, out_valid_in;
   nzt_pkg::nzt_result_type         result_ff, result_in;

   logic                            take;
   nzt_pkg::nzt_status_type         status;
   logic [nzt_pkg::MINSEC_W-1:0]    hh_raw;
   logic [nzt_pkg::HOUR_W-1:0]      hh;
   logic [nzt_pkg::HOUR_W-1:0]      off;
   logic [nzt_pkg::MINSEC_W-1:0]    mm;
   logic [nzt_pkg::MINSEC_W-1:0]    ss;
   logic [nzt_pkg::DAY_W-1:0]       day_c;
   logic [nzt_pkg::MONTH_W-1:0]     mon_c;
   logic [5:0]                      wrap_hour;
   logic [nzt_pkg::HOUR_W-1:0]      hour;
   logic [nzt_pkg::DAY_W-1:0]       day;
   logic [nzt_pkg::MONTH_W-1:0]     mon;
   logic [nzt_pkg::YEAR_W-1:0]      yr;

   assign in_ready  = !out_valid_ff || out_ready;
   assign take      = in_valid && in_ready;
   assign out_valid = out_valid_ff;
   assign out_item  = result_ff;

   // status priority: asterisk, checksum, year
   always_comb begin
      if (!in_item.saw_star) begin
         status = nzt_pkg::ST_NO_STAR;
      end else if (!in_item.sum_ok) begin
         status = nzt_pkg::ST_BAD_SUM;
      end else if (in_item.year < cfg.min_year) begin
         status = nzt_pkg::ST_OLD_YEAR;
      end else begin
         status = nzt_pkg::ST_OK;
      end
   end

   // convert time fields, clamp hour, offset, day and month
   always_comb begin
      hh_raw = nzt_pkg::bcd2_to_bin(in_item.time_bcd[23:16]);
      hh     = (hh_raw > 7'd23) ? nzt_pkg::HOUR_MAX : hh_raw[4:0];
      mm     = nzt_pkg::bcd2_to_bin(in_item.time_bcd[15:8]);
      ss     = nzt_pkg::bcd2_to_bin(in_item.time_bcd[7:0]);
      off    = (cfg.offset_hours > nzt_pkg::HOUR_MAX) ? nzt_pkg::HOUR_MAX : cfg.offset_hours;
      if (in_item.day == 14'd0) begin
         day_c = 5'd1;
      end else if (in_item.day > 14'd31) begin
         day_c = 5'd31;
      end else begin
         day_c = in_item.day[4:0];
      end
      if (in_item.month == 14'd0) begin
         mon_c = 4'd1;
      end else if (in_item.month > 14'd12) begin
         mon_c = 4'd12;
      end else begin
         mon_c = in_item.month[3:0];
      end
   end

   // hour shift with day, month and year borrow
   always_comb begin
      wrap_hour = 6'(hh) + 6'd24 - 6'(off);
      day       = day_c;
      mon       = mon_c;
      yr        = in_item.year;
      if (hh >= off) begin
         hour = hh - off;
      end else begin
         hour = wrap_hour[4:0];
         if (day_c > 5'd1) begin
            day = day_c - 5'd1;
         end else if (mon_c > 4'd1) begin
            mon = mon_c - 4'd1;
            day = nzt_pkg::month_days(mon_c - 4'd1, in_item.year[1:0] == 2'd0);
         end else begin
            mon = 4'd12;
            day = 5'd31;
            if (in_item.year != 14'd0) begin
               yr = in_item.year - 14'd1;
            end
         end
      end
   end

   // result item, zero fields unless ok
   always_comb begin
      out_valid_in = take || (out_valid_ff && !out_ready);
      result_in    = result_ff;
      if (take) begin
         result_in        = '0;
         result_in.status = status;
         if (status == nzt_pkg::ST_OK) begin
            result_in.year_out   = yr;
            result_in.month_out  = mon;
            result_in.day_out    = day;
            result_in.hour_out   = hour;
            result_in.minute_out = mm;
            result_in.second_out = ss;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      result_ff <= result_in;
   end

`ifndef SYNTH
   // rejected sentences carry only their status
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && result_ff.status != nzt_pkg::ST_OK |->
         result_ff.year_out == '0 && result_ff.month_out == '0 && result_ff.day_out == '0
         && result_ff.hour_out == '0 && result_ff.minute_out == '0
         && result_ff.second_out == '0)
      else $error("rejected result with non-zero fields");

   // accepted sentences give a month from 1 to 12, a nonzero day and a valid hour
   a_ok_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && result_ff.status == nzt_pkg::ST_OK |->
         result_ff.month_out >= 4'd1 && result_ff.month_out <= 4'd12
         && result_ff.day_out >= 5'd1 && result_ff.hour_out <= nzt_pkg::HOUR_MAX)
      else $error("local date or hour out of range");

   // a taken close always shows up as a result next cycle
   a_take_valid: assert property (@(posedge clock) disable iff (reset)
      take |=> out_valid_ff)
      else $error("taken close item lost");
`endif

endmodule

// ===== test/nmea_zda_time_parser_top_checker.sv =====
`timescale 1ns / 100ps
// nmea_zda_time_parser_top_checker: predicts local time results from accepted bytes and checks them
module nmea_zda_time_parser_top_checker (
   input  logic clock,
   input  logic reset,
   nzt_req_if   req_ch,
   nzt_rsp_if   rsp_ch,
   nzt_csr_if   csr_ch,
   output int   mismatch_count,
   output int   fixes_due,
   output int   fixes_seen
);

   typedef enum logic [1:0] {
      SCAN_IDLE,
      SCAN_BODY,
      SCAN_SUM
   } scan_phase_type;

   localparam int TIME_SAT    = 999999;
   localparam int NUM_SAT     = 9999;
   localparam int FIELD_TIME  = 1;
   localparam int FIELD_DAY   = 2;
   localparam int FIELD_MONTH = 3;
   localparam int FIELD_YEAR  = 4;
   localparam int FIELD_LAST  = 7;

   // sentence state
   scan_phase_type             scan_phase;
   logic [7:0]                 sum_xor;
   logic [7:0]                 sum_given;
   logic [2:0]                 field_idx;
   logic [19:0]                field_acc;
   logic [19:0]                time_acc;
   logic                       digits_done;
   logic                       cr_seen;
   logic                       star_seen;
   logic [nzt_pkg::YEAR_W-1:0] day_acc;
   logic [nzt_pkg::YEAR_W-1:0] month_acc;
   logic [nzt_pkg::YEAR_W-1:0] year_acc;

   // register copies
   logic [nzt_pkg::HOUR_W-1:0] offset_cfg;
   logic [nzt_pkg::YEAR_W-1:0] min_year_cfg;

   // local time results still to come out of the block
   nzt_pkg::nzt_result_type fix_q[$];

   initial begin
      mismatch_count = 0;
      fixes_due      = 0;
      fixes_seen     = 0;
   end

   task automatic start_sentence();
      sum_xor     = '0;
      sum_given   = '0;
      field_idx   = '0;
      field_acc   = '0;
      digits_done = 1'b0;
      time_acc    = '0;
      day_acc     = '0;
      month_acc   = '0;
      year_acc    = '0;
      cr_seen     = 1'b0;
      star_seen   = 1'b0;
      scan_phase  = SCAN_BODY;
   endtask

   function automatic int hex_nibble(input logic [7:0] c);
      if (c >= nzt_pkg::CH_ZERO && c <= nzt_pkg::CH_NINE) return int'(c - nzt_pkg::CH_ZERO);
      if (c >= nzt_pkg::CH_UPPER_A && c <= nzt_pkg::CH_UPPER_F)
         return int'(c - nzt_pkg::CH_UPPER_A) + 10;
      if (c >= nzt_pkg::CH_LOWER_A && c <= nzt_pkg::CH_LOWER_F)
         return int'(c - nzt_pkg::CH_LOWER_A) + 10;
      return -1;
   endfunction

   function automatic int days_in(input int mo, input int yy);
      case (mo)
         2:             return (yy % 4 == 0) ? 29 : 28;
         4, 6, 9, 11:   return 30;
         default:       return 31;
      endcase
   endfunction

   // comma latches the field, digits build it up until the first non-digit
   task automatic take_body_char(input logic [7:0] c);
      int v;
      if (c == nzt_pkg::CH_COMMA) begin
         case (int'(field_idx))
            FIELD_TIME:  time_acc  = field_acc;
            FIELD_DAY:   day_acc   = field_acc[nzt_pkg::YEAR_W-1:0];
            FIELD_MONTH: month_acc = field_acc[nzt_pkg::YEAR_W-1:0];
            FIELD_YEAR:  year_acc  = field_acc[nzt_pkg::YEAR_W-1:0];
            default: ;
         endcase
         field_acc   = '0;
         digits_done = 1'b0;
         if (field_idx < FIELD_LAST) field_idx = field_idx + 1'b1;
      end else if (c >= nzt_pkg::CH_ZERO && c <= nzt_pkg::CH_NINE) begin
         if (!digits_done) begin
            v = int'(field_acc) * 10 + int'(c - nzt_pkg::CH_ZERO);
            if (field_idx == FIELD_TIME) field_acc = (v > TIME_SAT) ? TIME_SAT : v;
            else field_acc = (v > NUM_SAT) ? NUM_SAT : v;
         end
      end else begin
         digits_done = 1'b1;
      end
   endtask

   // status and local time for a sentence closed by cr lf
   function automatic nzt_pkg::nzt_result_type local_fix();
      nzt_pkg::nzt_result_type r;
      int hh, mm, ss, dd, mo, yy, off;
      r = '0;
      if (!star_seen) begin
         r.status = nzt_pkg::ST_NO_STAR;
      end else if (sum_xor != sum_given) begin
         r.status = nzt_pkg::ST_BAD_SUM;
      end else if (year_acc < min_year_cfg) begin
         r.status = nzt_pkg::ST_OLD_YEAR;
      end else begin
         hh  = int'(time_acc) / 10000;
         mm  = (int'(time_acc) / 100) % 100;
         ss  = int'(time_acc) % 100;
         dd  = int'(day_acc);
         mo  = int'(month_acc);
         yy  = int'(year_acc);
         off = int'(offset_cfg);
         if (hh > 23) hh = 23;
         if (off > 23) off = 23;
         if (dd < 1) dd = 1;
         if (dd > 31) dd = 31;
         if (mo < 1) mo = 1;
         if (mo > 12) mo = 12;
         // step back across midnight, then month and year ends
         if (hh >= off) begin
            hh = hh - off;
         end else begin
            hh = hh + 24 - off;
            if (dd > 1) begin
               dd--;
            end else if (mo > 1) begin
               mo--;
               dd = days_in(mo, yy);
            end else begin
               mo = 12;
               dd = 31;
               if (yy > 0) yy--;
            end
         end
         r.status     = nzt_pkg::ST_OK;
         r.year_out   = yy[nzt_pkg::YEAR_W-1:0];
         r.month_out  = mo[nzt_pkg::MONTH_W-1:0];
         r.day_out    = dd[nzt_pkg::DAY_W-1:0];
         r.hour_out   = hh[nzt_pkg::HOUR_W-1:0];
         r.minute_out = mm[nzt_pkg::MINSEC_W-1:0];
         r.second_out = ss[nzt_pkg::MINSEC_W-1:0];
      end
      return r;
   endfunction

   task automatic parse_rx_byte(input logic [7:0] c);
      int h;
      if (c == nzt_pkg::CH_DOLLAR) begin
         start_sentence();
      end else if (scan_phase != SCAN_IDLE) begin
         if (c == nzt_pkg::CH_LF && cr_seen) begin
            fix_q.push_back(local_fix());
            scan_phase = SCAN_IDLE;
            cr_seen    = 1'b0;
         end else begin
            cr_seen = (c == nzt_pkg::CH_CR);
            if (scan_phase == SCAN_BODY) begin
               if (c == nzt_pkg::CH_STAR) begin
                  scan_phase  = SCAN_SUM;
                  star_seen   = 1'b1;
                  sum_given   = '0;
                  digits_done = 1'b0;
               end else begin
                  sum_xor = sum_xor ^ c;
                  take_body_char(c);
               end
            end else begin
               h = hex_nibble(c);
               if (h < 0) digits_done = 1'b1;
               else if (!digits_done) sum_given = {sum_given[3:0], h[3:0]};
            end
         end
      end
   endtask

   task automatic check_field(input string name, input logic [nzt_pkg::YEAR_W-1:0] want,
                              input logic [nzt_pkg::YEAR_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // watch the three channels at every rising edge
   always @(posedge clock) begin
      nzt_pkg::nzt_result_type want;
      if (reset) begin
         start_sentence();
         scan_phase   = SCAN_IDLE;
         offset_cfg   = nzt_pkg::OFFSET_RESET;
         min_year_cfg = nzt_pkg::MIN_YEAR_RESET;
         fix_q.delete();
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.reg_index)
               nzt_pkg::REG_OFFSET_HOURS:
                  offset_cfg   = csr_ch.wdata[nzt_pkg::HOUR_W-1:0];
               nzt_pkg::REG_MIN_YEAR:
                  min_year_cfg = csr_ch.wdata[nzt_pkg::YEAR_W-1:0];
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready) parse_rx_byte(req_ch.rx_byte);
         if (rsp_ch.valid && rsp_ch.ready) begin
            fixes_seen++;
            if (fix_q.size() == 0) begin
               $display("%0t: result with no sentence closed, expected nothing, got status %0d",
                        $time, rsp_ch.status);
               mismatch_count++;
            end else begin
               want = fix_q.pop_front();
               check_field("status", want.status, rsp_ch.status);
               check_field("year_out", want.year_out, rsp_ch.year_out);
               check_field("month_out", want.month_out, rsp_ch.month_out);
               check_field("day_out", want.day_out, rsp_ch.day_out);
               check_field("hour_out", want.hour_out, rsp_ch.hour_out);
               check_field("minute_out", want.minute_out, rsp_ch.minute_out);
               check_field("second_out", want.second_out, rsp_ch.second_out);
            end
         end
      end
      fixes_due = fix_q.size();
   end

endmodule

// ===== test/nmea_zda_time_parser_top_test.sv =====
`timescale 1ns / 100ps
// nmea_zda_time_parser_top_test: sentence stimulus, channel handshakes and verdict for the parser
module nmea_zda_time_parser_top_test;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int TOTAL_BYTES   = 1100;
   localparam int TAIL_BYTES    = 80;
   localparam int SETTLE_CYCLES = 6;

   // how a sentence is ended after its body
   typedef enum int {
      TAIL_UPPER,
      TAIL_LOWER,
      TAIL_WRONG,
      TAIL_NO_STAR,
      TAIL_ONE_DIGIT,
      TAIL_THREE_DIGITS,
      TAIL_JUNK,
      TAIL_SECOND_STAR,
      TAIL_LATE_LF
   } tail_kind_type;

   logic                       clock = 1'b0;
   logic                       reset;
   int                         cycle_count    = 0;
   int                         bytes_sent     = 0;
   int                         sentences_sent = 0;
   int                         stall_left     = 0;
   bit                         quiet_tail     = 1'b0;
   logic [nzt_pkg::YEAR_W-1:0] min_year_now   = nzt_pkg::MIN_YEAR_RESET;
   logic [7:0]                 body_q[$];
   int                         mismatch_count;
   int                         fixes_due;
   int                         fixes_seen;

   nzt_req_if req_ch ();
   nzt_rsp_if rsp_ch ();
   nzt_csr_if csr_ch ();

   nmea_zda_time_parser_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   nmea_zda_time_parser_top_checker fix_check (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_ch         (csr_ch),
      .mismatch_count (mismatch_count),
      .fixes_due      (fixes_due),
      .fixes_seen     (fixes_seen)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // result side drops ready in bursts of random length, except in the quiet tail
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= stall_left - 1;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= $urandom_range(0, 9);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // one byte item, with an occasional gap before it
   task automatic send_byte(input logic [7:0] b);
      @(negedge clock);
      if (!quiet_tail && $urandom_range(0, 11) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.rx_byte <= b;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      bytes_sent++;
   endtask

   // hold the byte stream until every result is out and the block has settled
   task automatic drain_fixes();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (fixes_due != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input nzt_pkg::nzt_reg_type idx,
                            input logic [nzt_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_ch.valid     <= 1'b1;
      csr_ch.reg_index <= idx;
      csr_ch.wdata     <= value;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
      if (idx == nzt_pkg::REG_MIN_YEAR) min_year_now = value[nzt_pkg::YEAR_W-1:0];
   endtask

   // new offset and minimum year, junk in the unused offset bits
   task automatic set_zone(input int offset, input int min_year);
      logic [nzt_pkg::CSR_DATA_W-1:0] w;
      drain_fixes();
      w = nzt_pkg::CSR_DATA_W'($urandom);
      w[nzt_pkg::HOUR_W-1:0] = offset[nzt_pkg::HOUR_W-1:0];
      write_reg(nzt_pkg::REG_OFFSET_HOURS, w);
      write_reg(nzt_pkg::REG_MIN_YEAR, min_year[nzt_pkg::CSR_DATA_W-1:0]);
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
      if (n < 10) return nzt_pkg::CH_ZERO + n;
      return (lower ? nzt_pkg::CH_LOWER_A : nzt_pkg::CH_UPPER_A) + n - 8'd10;
   endfunction

   // anything but a digit, a dollar, an asterisk or a comma
   function automatic logic [7:0] junk_char();
      logic [7:0] c;
      do c = 8'($urandom);
      while (c == nzt_pkg::CH_DOLLAR || c == nzt_pkg::CH_STAR || c == nzt_pkg::CH_COMMA
             || (c >= nzt_pkg::CH_ZERO && c <= nzt_pkg::CH_NINE));
      return c;
   endfunction

   function automatic logic [7:0] line_noise();
      logic [7:0] c;
      do c = 8'($urandom); while (c == nzt_pkg::CH_DOLLAR);
      return c;
   endfunction

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++) body_q.push_back(s[i]);
   endtask

   // decimal digits, zero padded to at least width
   task automatic add_number(input int v, input int width);
      logic [7:0] d[$];
      int n;
      n = v;
      do begin
         d.push_front(nzt_pkg::CH_ZERO + 8'(n % 10));
         n = n / 10;
      end while (n > 0);
      while (d.size() < width) d.push_front(nzt_pkg::CH_ZERO);
      foreach (d[i]) body_q.push_back(d[i]);
   endtask

   // a number, now and then broken by a stray character and more digits
   task automatic add_field(input int v, input int width);
      add_number(v, width);
      if ($urandom_range(0, 15) == 0) begin
         body_q.push_back(junk_char());
         add_number($urandom_range(0, 99), 1);
      end
   endtask

   task automatic send_sum(input logic [7:0] v, input bit lower);
      send_byte(hex_char(v[7:4], lower));
      send_byte(hex_char(v[3:0], lower));
   endtask

   // '$', the body, the checksum tail and cr lf
   task automatic emit_sentence(input tail_kind_type tail);
      logic [7:0] sum;
      bit lower;
      sum   = '0;
      lower = $urandom_range(0, 1);
      foreach (body_q[i]) sum = sum ^ body_q[i];
      send_byte(nzt_pkg::CH_DOLLAR);
      foreach (body_q[i]) send_byte(body_q[i]);
      if (tail != TAIL_NO_STAR) begin
         send_byte(nzt_pkg::CH_STAR);
         case (tail)
            TAIL_LOWER:        send_sum(sum, 1'b1);
            TAIL_WRONG:        send_sum(sum ^ 8'($urandom_range(1, 255)), lower);
            TAIL_ONE_DIGIT:    send_byte(hex_char(sum[3:0], lower));
            TAIL_THREE_DIGITS: begin
               send_byte(hex_char(4'($urandom), lower));
               send_sum(sum, lower);
            end
            TAIL_JUNK: begin
               send_sum(sum, lower);
               send_byte(junk_char());
               send_byte(hex_char(4'($urandom), lower));
            end
            TAIL_SECOND_STAR: begin
               send_byte(hex_char(sum[7:4], lower));
               send_byte(nzt_pkg::CH_STAR);
               send_byte(hex_char(sum[3:0], lower));
            end
            TAIL_LATE_LF: begin
               send_sum(sum, lower);
               send_byte(nzt_pkg::CH_CR);
               send_byte(nzt_pkg::CH_COMMA);
            end
            default:           send_sum(sum, 1'b0);
         endcase
      end
      send_byte(nzt_pkg::CH_CR);
      send_byte(nzt_pkg::CH_LF);
      sentences_sent++;
   endtask

   task automatic directed_fix(input string text, input tail_kind_type tail);
      body_q.delete();
      put_text(text);
      emit_sentence(tail);
   endtask

   // mostly well formed sentences with random dates, some broken ones
   task automatic random_fix();
      int tv, dd, mo, yy, pick;
      tail_kind_type tail;
      body_q.delete();
      if ($urandom_range(0, 3) == 0) put_text("GNZDA,");
      else put_text("GPZDA,");
      // time field
      tv = (($urandom_range(0, 9) == 0) ? $urandom_range(24, 99) : $urandom_range(0, 23)) * 10000
           + $urandom_range(0, 99) * 100 + $urandom_range(0, 99);
      pick = $urandom_range(0, 19);
      if (pick == 0) tv = $urandom_range(1000000, 99999999);
      if (pick != 1) add_field(tv, 6);
      if ($urandom_range(0, 2) == 0) begin
         body_q.push_back(".");
         add_number($urandom_range(0, 99), 2);
      end
      body_q.push_back(nzt_pkg::CH_COMMA);
      // day, month and year, with edge values favoured
      case ($urandom_range(0, 7))
         0:       dd = 1;
         1:       dd = 0;
         2:       dd = $urandom_range(32, 99);
         3:       dd = $urandom_range(10000, 999999);
         default: dd = $urandom_range(1, 31);
      endcase
      add_field(dd, 2);
      body_q.push_back(nzt_pkg::CH_COMMA);
      case ($urandom_range(0, 7))
         0:       mo = 1;
         1:       mo = 0;
         2:       mo = $urandom_range(13, 99);
         3:       mo = 3;
         default: mo = $urandom_range(1, 12);
      endcase
      add_field(mo, 2);
      body_q.push_back(nzt_pkg::CH_COMMA);
      case ($urandom_range(0, 7))
         0:       yy = $urandom_range(0, 9999);
         1:       yy = min_year_now;
         2:       yy = (min_year_now > 0) ? min_year_now - 1 : 0;
         3:       yy = 9999;
         4:       yy = $urandom_range(10000, 9999999);
         5:       yy = 0;
         default: yy = min_year_now + $urandom_range(0, 30);
      endcase
      add_field(yy, 4);
      // zone fields; sometimes none, so the year is ended by the star
      pick = $urandom_range(0, 9);
      if (pick == 1) put_text(",00,00,1,2,3,44");
      else if (pick != 0) put_text(",00,00");
      pick = $urandom_range(0, 99);
      if (pick < 40) tail = TAIL_UPPER;
      else if (pick < 70) tail = TAIL_LOWER;
      else if (pick < 78) tail = TAIL_WRONG;
      else if (pick < 83) tail = TAIL_NO_STAR;
      else if (pick < 86) tail = TAIL_ONE_DIGIT;
      else if (pick < 89) tail = TAIL_THREE_DIGITS;
      else if (pick < 93) tail = TAIL_JUNK;
      else if (pick < 96) tail = TAIL_SECOND_STAR;
      else tail = TAIL_LATE_LF;
      // line noise between sentences, or an abandoned sentence start
      if ($urandom_range(0, 4) == 0) begin
         repeat ($urandom_range(1, 4)) send_byte(line_noise());
      end
      if ($urandom_range(0, 19) == 0) begin
         send_byte(nzt_pkg::CH_DOLLAR);
         repeat ($urandom_range(1, 8)) send_byte(line_noise());
      end
      emit_sentence(tail);
   endtask

   task automatic run_sentences(input int n_bytes);
      int stop_at;
      stop_at = bytes_sent + n_bytes;
      while (bytes_sent < stop_at) random_fix();
   endtask

   initial begin
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.rx_byte   = '0;
      csr_ch.valid     = 1'b0;
      csr_ch.reg_index = nzt_pkg::REG_OFFSET_HOURS;
      csr_ch.wdata     = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: date extremes, borrows, each status
      directed_fix("GPZDA,235959.99,31,12,9999,00,00", TAIL_UPPER);
      directed_fix("GPZDA,000000,01,01,2024,00,00", TAIL_LOWER);
      directed_fix("GPZDA,020000,01,03,2028,,", TAIL_UPPER);
      directed_fix("GPZDA,120000,15,06,2024", TAIL_NO_STAR);
      directed_fix("GPZDA,120000,15,06,2024,", TAIL_WRONG);
      directed_fix("GPZDA,120000,15,06,2023,", TAIL_UPPER);
      directed_fix("GPZDA,053000,15,06,2025", TAIL_UPPER);
      directed_fix("GPZDA,99x2345,0,0,99999999,", TAIL_UPPER);
      run_sentences(120);

      // largest offset, no year limit: borrow at year zero
      set_zone(23, 0);
      directed_fix("GPZDA,000000,01,01,0000,", TAIL_UPPER);
      run_sentences(150);

      set_zone(0, 9999);
      run_sentences(120);

      // every bit of the year limit set: nothing passes
      set_zone(31, 16383);
      run_sentences(60);

      // offsets of a day or more are taken as 23 hours
      set_zone($urandom_range(24, 30), $urandom_range(0, 2100));
      run_sentences(150);

      // last part with no idling on either side
      set_zone($urandom_range(1, 22), $urandom_range(2000, 2030));
      quiet_tail = 1'b1;
      run_sentences((TOTAL_BYTES - bytes_sent > TAIL_BYTES) ? TOTAL_BYTES - bytes_sent
                                                            : TAIL_BYTES);
      drain_fixes();

      $display("covered %0d bytes in %0d sentences, %0d results compared, %0d mismatches",
               bytes_sent, sentences_sent, fixes_seen, mismatch_count);
      $display("zones ranged over offsets 0 to 31 and year limits 0 to 16383, stalls both sides");
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/nzt_pkg.sv
rtl/nzt_if.sv
rtl/nzt_parser.sv
rtl/nzt_local_time.sv
rtl/nmea_zda_time_parser_top.sv
test/nmea_zda_time_parser_top_checker.sv
test/nmea_zda_time_parser_top_test.sv
